>>> rtl/dmsp_pkg.sv
// Shared constants and types for the Dijkstra shortest-path block.
package dmsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int VTX_BITS     = $clog2(MAX_VERTICES);
    localparam int ADDR_BITS    = 2 * VTX_BITS;
    localparam int CNT_BITS     = VTX_BITS + 1;
    localparam int SRC_BITS     = 4;
    localparam int DIST_BITS    = 20;
    localparam int DENT_BITS    = DIST_BITS + 1;
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]  CNT_MIN  = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0]  CNT_MAX  = CNT_BITS'(MAX_VERTICES);
    localparam logic [CNT_BITS-1:0]  CNT_RESET = CNT_BITS'(16);

    // register index codes (word address bit)
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [SRC_BITS-1:0] source;
        logic [CNT_BITS-1:0] count;
    } cfg_t;

endpackage

>>> rtl/dmsp_ram.sv
// Generic simple dual-port RAM with registered read.
module dmsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dmsp_cfg.sv
// APB configuration registers: source vertex and vertex count.
module dmsp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmsp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [dmsp_pkg::PDATA_BITS-1:0] pwdata,
    output logic [dmsp_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    output dmsp_pkg::cfg_t                  cfg
);
    import dmsp_pkg::*;

    logic [SRC_BITS-1:0] source_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= '0;
            count_reg  <= CNT_RESET;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_SOURCE: source_reg <= pwdata[SRC_BITS-1:0];
                REG_COUNT:  count_reg  <= pwdata[CNT_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SOURCE: prdata = PDATA_BITS'(source_reg);
            REG_COUNT:  prdata = PDATA_BITS'(count_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.source = source_reg;
    assign cfg.count  = count_reg;

endmodule

>>> rtl/dmsp_core.sv
// Search engine: weight matrix and distance memories, pass sequencer, result beat.
module dmsp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dmsp_pkg::cfg_t         cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,
    output logic [0:0]             m_tuser,
    output logic                   m_tlast
);
    import dmsp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_INIT     = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_RELAX    = 7'b0001000,
        ST_OUT_RD   = 7'b0010000,
        ST_OUT_LD   = 7'b0100000,
        ST_OUT_WAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [VTX_BITS-1:0]        cnt_reg, cnt_next;
    logic                       issue_reg, issue_next;
    logic                       p1_valid_reg, p1_valid_next;
    logic [VTX_BITS-1:0]        p1_idx_reg, p1_idx_next;
    logic                       p1_wvalid_reg, p1_wvalid_next;
    logic [VTX_BITS-1:0]        pass_reg, pass_next;
    logic [VTX_BITS-1:0]        best_idx_reg, best_idx_next;
    logic [DIST_BITS-1:0]       best_dist_reg, best_dist_next;
    logic                       best_fin_reg, best_fin_next;
    logic                       best_have_reg, best_have_next;
    logic [MAX_VERTICES-1:0]    done_reg, done_next;
    logic [MAX_VERTICES*MAX_VERTICES-1:0] wvalid_reg;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [VTX_BITS-1:0]        out_idx_reg, out_idx_next;
    logic [DIST_BITS-1:0]       out_dist_reg, out_dist_next;
    logic                       out_reach_reg, out_reach_next;
    logic                       out_last_reg, out_last_next;

    logic                       s_accept;
    logic [VTX_BITS-1:0]        in_row, in_col;
    logic [WEIGHT_BITS-1:0]     in_weight;
    logic [CNT_BITS-1:0]        n_eff;
    logic [VTX_BITS-1:0]        n_last;
    logic                       src_ok;

    logic                       dist_we;
    logic [VTX_BITS-1:0]        dist_waddr, dist_raddr;
    logic [DENT_BITS-1:0]       dist_wdata, dist_rdata;
    logic [ADDR_BITS-1:0]       w_raddr;
    logic [WEIGHT_BITS-1:0]     w_rdata, w_eff;

    logic                       c_fin;
    logic [DIST_BITS-1:0]       c_dist;
    logic                       take;
    logic                       no_worse;
    logic [VTX_BITS-1:0]        bi_now;
    logic [DIST_BITS-1:0]       bd_now;
    logic                       bf_now, bh_now;
    logic [DENT_BITS-1:0]       sum_raw;
    logic [DIST_BITS-1:0]       sum_sat;
    logic                       pass_last;

    assign in_row    = s_tdata[3:0];
    assign in_col    = s_tdata[7:4];
    assign in_weight = s_tdata[23:8];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;

    assign n_eff  = (cfg.count < CNT_MIN) ? CNT_MIN :
                    (cfg.count > CNT_MAX) ? CNT_MAX : cfg.count;
    assign n_last = VTX_BITS'(n_eff - CNT_BITS'(1));
    assign src_ok = (CNT_BITS'(cfg.source) < n_eff);
    assign pass_last = ((pass_reg + VTX_BITS'(1)) == n_last);

    dmsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_wmem (
        .clk   (clk),
        .we    (s_accept),
        .waddr ({in_row, in_col}),
        .wdata (in_weight),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dmsp_ram #(.WIDTH(DENT_BITS), .DEPTH(MAX_VERTICES)) u_dmem (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    // never-written matrix entries read as no edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (s_accept)
        begin
            wvalid_reg[{in_row, in_col}] <= 1'b1;
        end
    end

    assign c_fin  = dist_rdata[DIST_BITS];
    assign c_dist = dist_rdata[DIST_BITS-1:0];
    assign w_eff  = p1_wvalid_reg ? w_rdata : '0;

    // candidate selection, ties go to the later (higher) index
    always_comb
    begin
        if (!c_fin)
        begin
            no_worse = !best_fin_reg;
        end
        else
        begin
            no_worse = !best_fin_reg || (c_dist <= best_dist_reg);
        end
        take   = !done_reg[p1_idx_reg] && (!best_have_reg || no_worse);
        bi_now = take ? p1_idx_reg : best_idx_reg;
        bd_now = take ? c_dist : best_dist_reg;
        bf_now = take ? c_fin : best_fin_reg;
        bh_now = take | best_have_reg;
    end

    assign sum_raw = {1'b0, best_dist_reg} + DENT_BITS'(w_eff);
    assign sum_sat = sum_raw[DIST_BITS] ? DIST_MAX : sum_raw[DIST_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = cnt_reg;
        p1_wvalid_next = wvalid_reg[{best_idx_reg, cnt_reg}];
        pass_next      = pass_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_fin_next  = best_fin_reg;
        best_have_next = best_have_reg;
        done_next      = done_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        out_reach_next = out_reach_reg;
        out_last_next  = out_last_reg;
        dist_we        = 1'b0;
        dist_waddr     = p1_idx_reg;
        dist_wdata     = '0;
        dist_raddr     = cnt_reg;
        w_raddr        = {best_idx_reg, cnt_reg};

        if ((state_reg == ST_SCAN || state_reg == ST_RELAX) && issue_reg)
        begin
            p1_valid_next = 1'b1;
            cnt_next      = cnt_reg + VTX_BITS'(1);
            if (cnt_reg == n_last)
            begin
                issue_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_tlast)
                begin
                    state_next = ST_INIT;
                    cnt_next   = '0;
                end
            end
            ST_INIT:
            begin
                dist_we    = 1'b1;
                dist_waddr = cnt_reg;
                dist_wdata = {(src_ok && cnt_reg == VTX_BITS'(cfg.source)), {DIST_BITS{1'b0}}};
                done_next  = '0;
                cnt_next   = cnt_reg + VTX_BITS'(1);
                if (cnt_reg == VTX_BITS'(MAX_VERTICES - 1))
                begin
                    state_next     = ST_SCAN;
                    cnt_next       = '0;
                    issue_next     = 1'b1;
                    best_have_next = 1'b0;
                    best_fin_next  = 1'b0;
                    pass_next      = '0;
                end
            end
            ST_SCAN:
            begin
                if (p1_valid_reg)
                begin
                    best_idx_next  = bi_now;
                    best_dist_next = bd_now;
                    best_fin_next  = bf_now;
                    best_have_next = bh_now;
                    if (p1_idx_reg == n_last)
                    begin
                        cnt_next   = '0;
                        issue_next = 1'b1;
                        if (!bh_now)
                        begin
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            done_next[bi_now] = 1'b1;
                            if (bf_now)
                            begin
                                state_next = ST_RELAX;
                            end
                            else if (pass_last)
                            begin
                                state_next = ST_OUT_RD;
                            end
                            else
                            begin
                                pass_next      = pass_reg + VTX_BITS'(1);
                                best_have_next = 1'b0;
                                best_fin_next  = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_RELAX:
            begin
                if (p1_valid_reg)
                begin
                    if (!done_reg[p1_idx_reg] && w_eff != '0 &&
                        (!c_fin || sum_sat < c_dist))
                    begin
                        dist_we    = 1'b1;
                        dist_wdata = {1'b1, sum_sat};
                    end
                    if (p1_idx_reg == n_last)
                    begin
                        cnt_next   = '0;
                        issue_next = 1'b1;
                        if (pass_last)
                        begin
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            state_next     = ST_SCAN;
                            pass_next      = pass_reg + VTX_BITS'(1);
                            best_have_next = 1'b0;
                            best_fin_next  = 1'b0;
                        end
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                out_idx_next   = cnt_reg;
                out_dist_next  = c_fin ? c_dist : '0;
                out_reach_next = c_fin;
                out_last_next  = (cnt_reg == n_last);
                m_tvalid_next  = 1'b1;
                state_next     = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (cnt_reg == n_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + VTX_BITS'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            p1_valid_reg  <= 1'b0;
            pass_reg      <= '0;
            best_have_reg <= 1'b0;
            best_fin_reg  <= 1'b0;
            done_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            p1_valid_reg  <= p1_valid_next;
            pass_reg      <= pass_next;
            best_have_reg <= best_have_next;
            best_fin_reg  <= best_fin_next;
            done_reg      <= done_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg     <= p1_idx_next;
        p1_wvalid_reg  <= p1_wvalid_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        out_idx_reg    <= out_idx_next;
        out_dist_reg   <= out_dist_next;
        out_reach_reg  <= out_reach_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_dist_reg, out_idx_reg};
    assign m_tuser  = out_reach_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_beat_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (state_reg == ST_OUT_WAIT))
        else $error("result beat outside output wait");

    a_dist_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        dist_we |-> (state_reg == ST_INIT || state_reg == ST_RELAX))
        else $error("distance write outside init or relax");

    a_relax_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX) |-> done_reg[best_idx_reg])
        else $error("relaxing from an unfinished vertex");

    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> (state_reg == ST_INIT))
        else $error("last entry did not start a run");
`endif

endmodule

>>> rtl/dijkstra_matrix_shortest_path.sv
// Top level of the adjacency-matrix Dijkstra shortest-path block.
//
// Matrix entries are written one beat per cycle, while idle, into a 256-entry
// weight memory that reads as no edge until written. A beat with tlast set writes
// its entry and starts a run: the distance memory is preset for all 16 vertices,
// then n-1 passes of a minimum scan and, when the picked vertex is finite, an
// edge relaxation, then one result beat per vertex, each held until taken.
// Each phase walks the single read port of the distance memory once per vertex.
// No input beat is taken while a run or its results are in progress.
module dijkstra_matrix_shortest_path (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmsp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [dmsp_pkg::PDATA_BITS-1:0] pwdata,
    output logic [dmsp_pkg::PDATA_BITS-1:0] prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // row_vertex, col_vertex, edge_weight
    input  logic                            s_tlast,   // last_entry
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // vertex_index, distance
    output logic [0:0]                      m_tuser,   // reachable
    output logic                            m_tlast    // last_result
);
    import dmsp_pkg::*;

    cfg_t cfg;

    dmsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmsp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
